// ===== src/prd_pkg.sv =====
// Shared types and constants of the palette run-length pixel decoder.
`timescale 1ns / 1ps

package prd_pkg;

    localparam int IDX_W      = 8;
    localparam int COLOR_W    = 32;
    localparam int BYTE_W     = 8;
    localparam int OP_W       = 2;
    localparam int MODE_W     = 3;
    localparam int SIDE_IN_W  = 12;
    localparam int POS_OUT_W  = 22;
    localparam int CNT_W      = 2;
    localparam int RUN_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int PIXELS_PER_RESULT = 2;
    localparam int GROUP             = (PIXELS_PER_RESULT >= 2) ? 2 : 1;
    localparam int RESULT_LIMIT      = 64;

    localparam logic [OP_W-1:0] OP_DATA    = 2'd0;
    localparam logic [OP_W-1:0] OP_PALETTE = 2'd1;
    localparam logic [OP_W-1:0] OP_FRAME   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_1BIT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_2BIT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_4BIT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BYTE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIT_RLE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RUN_RLE = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
        logic issue;
    } t_cmd;

    typedef struct packed {
        logic has_results;
        logic issue_ok;
        logic last_issue;
    } t_status;

endpackage

// ===== src/prd_palette.sv =====
// Palette store: one write port, two registered read ports, per-entry valid bits.
`timescale 1ns / 1ps

module prd_palette import prd_pkg::*; #(
    parameter int ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [IDX_W-1:0]   i_waddr,
    input  logic [COLOR_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [IDX_W-1:0]   i_raddr_a,
    input  logic [IDX_W-1:0]   i_raddr_b,
    output logic [COLOR_W-1:0] o_rdata_a,
    output logic [COLOR_W-1:0] o_rdata_b
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W:0] ENTRIES_L = (IDX_W + 1)'(ENTRIES);

    logic [COLOR_W-1:0] r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [COLOR_W-1:0] r_q_a;
    logic [COLOR_W-1:0] r_q_b;
    logic               r_ok_a;
    logic               r_ok_b;

    logic w_wr_ok;
    logic w_in_a;
    logic w_in_b;

    assign w_wr_ok = i_we && ({1'b0, i_waddr} < ENTRIES_L);
    assign w_in_a  = {1'b0, i_raddr_a} < ENTRIES_L;
    assign w_in_b  = {1'b0, i_raddr_b} < ENTRIES_L;

    always_ff @(posedge i_clk) begin
        if (w_wr_ok) begin
            r_mem[i_waddr[AW-1:0]] <= i_wdata;
        end
        if (i_re) begin
            r_q_a <= r_mem[i_raddr_a[AW-1:0]];
            r_q_b <= r_mem[i_raddr_b[AW-1:0]];
        end
    end

    // an entry never written reads as zero, as does an index past the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ok_a  <= 1'b0;
            r_ok_b  <= 1'b0;
        end else begin
            if (w_wr_ok) begin
                r_valid[i_waddr[AW-1:0]] <= 1'b1;
            end
            if (i_re) begin
                r_ok_a <= w_in_a && r_valid[i_raddr_a[AW-1:0]];
                r_ok_b <= w_in_b && r_valid[i_raddr_b[AW-1:0]];
            end
        end
    end

    assign o_rdata_a = r_ok_a ? r_q_a : '0;
    assign o_rdata_b = r_ok_b ? r_q_b : '0;

endmodule

// ===== src/prd_datapath.sv =====
// Datapath: configuration, byte parsing, position tracking, palette lookup and result stages.
`timescale 1ns / 1ps

module prd_datapath import prd_pkg::*; #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_SIDE        = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [OP_W-1:0]       i_op,
    input  logic [BYTE_W-1:0]     i_byte_value,
    input  logic [IDX_W-1:0]      i_palette_index,
    input  logic [COLOR_W-1:0]    i_palette_color,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [POS_OUT_W-1:0]  o_pixel_position,
    output logic [COLOR_W-1:0]    o_color_first,
    output logic [COLOR_W-1:0]    o_color_second,
    output logic [CNT_W-1:0]      o_pixel_count,
    output logic                  o_last
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int TOT_W  = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int WIDE_W = TOT_W + 8;
    localparam logic [SIDE_IN_W:0] MAX_SIDE_L = (SIDE_IN_W + 1)'(MAX_SIDE);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RUN,
        PH_LITERAL
    } t_phase;

    // configuration
    logic [MODE_W-1:0]    r_mode;
    logic [SIDE_IN_W-1:0] r_width;
    logic [SIDE_IN_W-1:0] r_height;
    logic [TOT_W-1:0]     r_total;

    // latched input word
    logic [OP_W-1:0]    r_op;
    logic [BYTE_W-1:0]  r_byte;
    logic [IDX_W-1:0]   r_pidx;
    logic [COLOR_W-1:0] r_pcol;

    // frame and parser state
    logic [TOT_W-1:0] r_pos;
    t_phase           r_phase;
    logic [RUN_W-1:0] r_rc;

    // per-byte result sequencing
    logic [RUN_W-1:0]  r_res_left;
    logic [RUN_W-1:0]  r_pix_left;
    logic [TOT_W-1:0]  r_res_pos;
    logic [BYTE_W-1:0] r_sh;

    // read stage and output register
    logic             r_pend_valid;
    logic [TOT_W-1:0] r_pend_pos;
    logic [CNT_W-1:0] r_pend_cnt;
    logic             r_pend_last;
    logic             r_out_valid;
    logic [TOT_W-1:0] r_out_pos;
    logic [COLOR_W-1:0] r_out_c1;
    logic [COLOR_W-1:0] r_out_c2;
    logic [CNT_W-1:0] r_out_cnt;
    logic             r_out_last;

    logic [SIDE_W-1:0]   w_cw;
    logic [SIDE_W-1:0]   w_ch;
    logic [2*SIDE_W-1:0] w_prod;
    logic                w_rle;
    t_phase              n_phase;
    logic [RUN_W-1:0]    n_rc;
    logic [RUN_W-1:0]    w_rle_n;
    logic [RUN_W-1:0]    w_npix;
    logic [TOT_W-1:0]    w_avail;
    logic [RUN_W-1:0]    w_take;
    logic [RUN_W-1:0]    w_res_raw;
    logic [RUN_W-1:0]    w_res;
    logic                w_two;
    logic [IDX_W-1:0]    w_idx_a;
    logic [IDX_W-1:0]    w_idx_b;
    logic [BYTE_W-1:0]   w_sh_next;
    logic                w_load_out;
    logic                w_issue_ok;
    logic                w_pal_we;
    logic [COLOR_W-1:0]  w_rd_a;
    logic [COLOR_W-1:0]  w_rd_b;

    // shift the packed byte on by one pixel
    function automatic logic [BYTE_W-1:0] f_step(input logic [MODE_W-1:0] md,
                                                 input logic [BYTE_W-1:0] sh);
        logic [BYTE_W-1:0] res;
        unique case (md)
            MODE_1BIT: res = BYTE_W'(sh << 1);
            MODE_2BIT: res = BYTE_W'(sh << 2);
            MODE_4BIT: res = BYTE_W'(sh << 4);
            default:   res = '0;
        endcase
        return res;
    endfunction

    // index of the pixel at the top of the shifted byte
    function automatic logic [IDX_W-1:0] f_index(input logic [MODE_W-1:0] md,
                                                 input logic [BYTE_W-1:0] sh,
                                                 input logic [BYTE_W-1:0] bv);
        logic [IDX_W-1:0] res;
        unique case (md)
            MODE_1BIT: res = {7'd0, sh[7]};
            MODE_2BIT: res = {6'd0, sh[7:6]};
            MODE_4BIT: res = {4'd0, sh[7:4]};
            MODE_BYTE: res = sh;
            default:   res = bv;
        endcase
        return res;
    endfunction

    assign w_cw   = ({1'b0, r_width} > MAX_SIDE_L) ? SIDE_W'(MAX_SIDE) : SIDE_W'(r_width);
    assign w_ch   = ({1'b0, r_height} > MAX_SIDE_L) ? SIDE_W'(MAX_SIDE) : SIDE_W'(r_height);
    assign w_prod = w_cw * w_ch;

    assign w_rle = (r_mode == MODE_LIT_RLE) || (r_mode == MODE_RUN_RLE);

    always_comb begin
        n_phase = r_phase;
        n_rc    = r_rc;
        w_rle_n = '0;
        unique case (r_phase)
            PH_RUN: begin
                w_rle_n = r_rc;
                n_rc    = '0;
                n_phase = PH_HEADER;
            end
            PH_LITERAL: begin
                w_rle_n = RUN_W'(1);
                n_rc    = (r_rc != '0) ? r_rc - RUN_W'(1) : '0;
                if (n_rc == '0) begin
                    n_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (r_mode == MODE_LIT_RLE) begin
                    if (!r_byte[7]) begin
                        w_rle_n = RUN_W'(1);
                    end else begin
                        n_rc    = r_byte[6:0];
                        n_phase = PH_RUN;
                    end
                end else if (!r_byte[7]) begin
                    n_rc    = r_byte[6:0];
                    n_phase = PH_RUN;
                end else begin
                    n_rc    = r_byte[6:0];
                    n_phase = (r_byte[6:0] != '0) ? PH_LITERAL : PH_HEADER;
                end
            end
        endcase
    end

    always_comb begin
        w_npix = '0;
        if (r_op == OP_DATA) begin
            unique case (r_mode)
                MODE_1BIT:    w_npix = RUN_W'(8);
                MODE_2BIT:    w_npix = RUN_W'(4);
                MODE_4BIT:    w_npix = RUN_W'(2);
                MODE_BYTE:    w_npix = RUN_W'(1);
                MODE_LIT_RLE: w_npix = w_rle_n;
                MODE_RUN_RLE: w_npix = w_rle_n;
                default:      w_npix = '0;
            endcase
        end
    end

    // keep only the pixels that still fit in the frame
    assign w_avail   = (r_pos >= r_total) ? '0 : r_total - r_pos;
    assign w_take    = (WIDE_W'(w_avail) < WIDE_W'(w_npix)) ? RUN_W'(w_avail) : w_npix;
    assign w_res_raw = (GROUP == 2) ? RUN_W'((8'(w_take) + 8'd1) >> 1) : w_take;
    assign w_res     = (w_res_raw > RUN_W'(RESULT_LIMIT)) ? RUN_W'(RESULT_LIMIT) : w_res_raw;

    assign w_two     = (GROUP == 2) && (r_pix_left >= RUN_W'(2));
    assign w_idx_a   = f_index(r_mode, r_sh, r_byte);
    assign w_idx_b   = f_index(r_mode, f_step(r_mode, r_sh), r_byte);
    assign w_sh_next = (GROUP == 2) ? f_step(r_mode, f_step(r_mode, r_sh)) : f_step(r_mode, r_sh);

    assign w_load_out = r_pend_valid && (!r_out_valid || i_out_ready);
    assign w_issue_ok = !r_pend_valid || w_load_out;
    assign w_pal_we   = i_cmd.exec && (r_op == OP_PALETTE);

    assign o_status.has_results = (r_op == OP_DATA) && (w_take != '0);
    assign o_status.issue_ok    = w_issue_ok;
    assign o_status.last_issue  = (r_res_left == RUN_W'(1));

    prd_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_pal_we),
        .i_waddr   (r_pidx),
        .i_wdata   (r_pcol),
        .i_re      (i_cmd.issue),
        .i_raddr_a (w_idx_a),
        .i_raddr_b (w_idx_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_byte <= i_byte_value;
            r_pidx <= i_palette_index;
            r_pcol <= i_palette_color;
        end
        if (i_cmd.exec) begin
            r_pix_left <= w_take;
            r_res_pos  <= r_pos;
            r_sh       <= r_byte;
        end else if (i_cmd.issue) begin
            r_pix_left <= r_pix_left - (w_two ? RUN_W'(2) : RUN_W'(1));
            r_res_pos  <= r_res_pos + TOT_W'(GROUP);
            r_sh       <= w_sh_next;
        end
        if (i_cmd.issue) begin
            r_pend_pos  <= r_res_pos;
            r_pend_cnt  <= w_two ? CNT_W'(2) : CNT_W'(1);
            r_pend_last <= (r_res_left == RUN_W'(1));
        end
        if (w_load_out) begin
            r_out_pos  <= r_pend_pos;
            r_out_c1   <= w_rd_a;
            r_out_c2   <= (r_pend_cnt == CNT_W'(2)) ? w_rd_b : '0;
            r_out_cnt  <= r_pend_cnt;
            r_out_last <= r_pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_BYTE;
            r_width      <= SIDE_IN_W'(1);
            r_height     <= SIDE_IN_W'(1);
            r_total      <= TOT_W'(1);
            r_pos        <= '0;
            r_phase      <= PH_HEADER;
            r_rc         <= '0;
            r_res_left   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_total <= w_prod[TOT_W-1:0];
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                    REG_WIDTH:  r_width  <= i_cfg_data[SIDE_IN_W-1:0];
                    REG_HEIGHT: r_height <= i_cfg_data[SIDE_IN_W-1:0];
                    default:    ;
                endcase
            end
            if (i_cmd.exec) begin
                unique case (r_op)
                    OP_DATA: begin
                        r_pos      <= r_pos + TOT_W'(w_take);
                        r_res_left <= w_res;
                        if (w_rle) begin
                            r_phase <= n_phase;
                            r_rc    <= n_rc;
                        end
                    end
                    OP_FRAME: begin
                        r_pos   <= '0;
                        r_phase <= PH_HEADER;
                        r_rc    <= '0;
                    end
                    default: ;
                endcase
            end else if (i_cmd.issue) begin
                r_res_left <= r_res_left - RUN_W'(1);
            end
            if (i_cmd.issue) begin
                r_pend_valid <= 1'b1;
            end else if (w_load_out) begin
                r_pend_valid <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pixel_position = POS_OUT_W'(r_out_pos);
    assign o_color_first    = r_out_c1;
    assign o_color_second   = r_out_c2;
    assign o_pixel_count    = r_out_cnt;
    assign o_last           = r_out_last;

    a_issue_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> r_res_left != '0)
        else $error("read issued with no result left for this byte");

    a_no_pend_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.issue && r_pend_valid) |-> w_load_out)
        else $error("pending result overwritten before it moved on");

    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cnt == CNT_W'(1) || r_out_cnt == CNT_W'(2)))
        else $error("result word with a bad pixel count");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == OP_FRAME) |=> (r_pos == '0 && r_phase == PH_HEADER))
        else $error("frame start did not clear position and parser");

endmodule

// ===== src/prd_ctrl.sv =====
// Controller: sequences accept, execute and result issue for each input word.
`timescale 1ns / 1ps

module prd_ctrl import prd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_cfg_we,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_STREAM
    } t_state;

    t_state r_state;
    t_state n_state;

    // hold off a word in a cycle that writes configuration
    assign o_in_ready = (r_state == S_IDLE) && !i_cfg_we;

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        o_cmd.issue = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid && o_in_ready;
                if (o_cmd.load) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.has_results ? S_STREAM : S_IDLE;
            end
            S_STREAM: begin
                o_cmd.issue = i_status.issue_ok;
                if (i_status.issue_ok && i_status.last_issue) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/palette_rle_pixel_decoder.sv =====
// Top level of the palette run-length pixel decoder.
`timescale 1ns / 1ps

// Input words arrive on the s_axis channel: tuser carries the op (data byte,
// palette write, frame start), tdata the byte, palette index and colour.
// Results leave on m_axis, one word per one or two pixels, tlast on the final
// word a byte produces. The user writes configuration (mode, width, height)
// on the plain write port only while the block is idle; the block does not
// enforce this. s_axis_tready drops in a cycle with a configuration write.
// A palette write or frame start passes accept and execute; a data byte
// passes accept, execute and one issue per result word (up to 4 for a
// one-bit byte, up to 64 for a long run), the two-port palette read issuing
// one word per cycle unless the output stalls. The first word passes the
// read stage and output register; a byte wholly past the frame gives no word.
// Reset clears the palette to zero, selects byte-index mode, a 1x1 frame,
// position zero and the header phase of the run-length parser.
// When the receiver stalls, up to two words wait in the read stage and the
// output register; issue halts and the next input word waits until the
// current byte has issued all of its words.
module palette_rle_pixel_decoder import prd_pkg::*; #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_SIDE        = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // byte_value [7:0], palette_index [15:8], palette_color [47:16]
    input  logic [47:0]           s_axis_tdata,
    // op [1:0]
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_position [21:0], color_first [53:22], color_second [85:54],
    // pixel_count [87:86]
    output logic [87:0]           m_axis_tdata,
    output logic                  m_axis_tlast
);

    t_cmd                 w_cmd;
    t_status              w_status;
    logic [POS_OUT_W-1:0] w_pos;
    logic [COLOR_W-1:0]   w_c1;
    logic [COLOR_W-1:0]   w_c2;
    logic [CNT_W-1:0]     w_cnt;

    prd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_cfg_we   (i_cfg_we),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    prd_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .MAX_SIDE        (MAX_SIDE)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_op             (s_axis_tuser),
        .i_byte_value     (s_axis_tdata[7:0]),
        .i_palette_index  (s_axis_tdata[15:8]),
        .i_palette_color  (s_axis_tdata[47:16]),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_pixel_position (w_pos),
        .o_color_first    (w_c1),
        .o_color_second   (w_c2),
        .o_pixel_count    (w_cnt),
        .o_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {w_cnt, w_c2, w_c1, w_pos};

endmodule
